>>> design/scfr_pkg.sv
package scfr_pkg;

   // beat widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 5;

   // framing bytes
   localparam logic [BYTE_W-1:0] HEADER_BYTE    = 8'h5C;
   localparam logic [BYTE_W-1:0] TRAILER_BYTE   = 8'hBB;
   localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd2;

   // receiver phases
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN     = 3'd1,
      PH_BODY    = 3'd2,
      PH_CHECK   = 3'd3,
      PH_TRAILER = 3'd4,
      PH_REPLAY  = 3'd5
   } phase_type;

endpackage

>>> design/scfr_ifs.sv
// received byte stream
interface scfr_req_if
   import scfr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// validated payload stream
interface scfr_rsp_if
   import scfr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  payload_byte;
   logic [INDEX_W-1:0] byte_index;
   logic               last_byte;

   modport source (output valid, output payload_byte, output byte_index,
                   output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input byte_index,
                   input last_byte, output ready);
endinterface

>>> design/sum_checksum_frame_receiver.sv
// Channel   Dir  Beat fields                               Accepted when
// req_if    in   rx_byte[7:0]                              valid && ready
// rsp_if    out  payload_byte[7:0] byte_index[4:0] last    valid && ready
//
// One received byte per cycle in the hunt, length, body, check and trailer phases.
// A good trailer starts a replay of N payload bytes from the buffer, one beat per
// cycle when not stalled, each read through the single buffer read port.
// Input ready is low for the whole replay, so writes and reads never overlap.
// Synchronous active-high reset returns to the header hunt; no buffer clearing pass.
// A stalled result beat holds its read data; the buffer read is not re-issued.
module sum_checksum_frame_receiver
   import scfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic        clock,
   input  logic        reset,
   scfr_req_if.sink    req_if,
   scfr_rsp_if.source  rsp_if
);

   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD) + FRAME_OVERHEAD;

   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rcvd_ff, rcvd_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept, beat, last, len_ok, body_done, trailer_ok;
   logic [BYTE_W-1:0] rx;
   logic              wr_en, rd_en;
   logic [AW-1:0]     rd_addr;

   assign rx         = req_if.rx_byte;
   assign accept     = req_if.valid && req_if.ready;
   assign beat       = rsp_valid_ff && rsp_if.ready;
   assign last       = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign len_ok     = (rx > FRAME_OVERHEAD) && (rx <= MAX_LEN);
   assign body_done  = (rcvd_ff + CW'(1)) == count_ff;
   assign trailer_ok = accept && (phase_ff == PH_TRAILER) && (rx == TRAILER_BYTE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LEN: begin
            if (accept) phase_in = len_ok ? PH_BODY : PH_HUNT;
         end
         PH_BODY: begin
            if (accept && body_done) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            if (accept) phase_in = (rx == sum_ff) ? PH_TRAILER : PH_HUNT;
         end
         PH_TRAILER: begin
            if (accept) phase_in = (rx == TRAILER_BYTE) ? PH_REPLAY : PH_HUNT;
         end
         PH_REPLAY: begin
            if (beat && last) phase_in = PH_HUNT;
         end
         default: begin
            if (accept && rx == HEADER_BYTE) phase_in = PH_LEN;
            else                             phase_in = PH_HUNT;
         end
      endcase
   end

   // handshake and buffer control
   always_comb begin
      req_if.ready = (phase_ff != PH_REPLAY);
      wr_en        = accept && (phase_ff == PH_BODY);
      rd_en        = trailer_ok || ((phase_ff == PH_REPLAY) && beat && !last);
      rd_addr      = trailer_ok ? '0 : idx_ff + AW'(1);
      rsp_valid_in = rsp_valid_ff;
      if (trailer_ok) begin
         rsp_valid_in = 1'b1;
      end else if ((phase_ff == PH_REPLAY) && beat && last) begin
         rsp_valid_in = 1'b0;
      end
   end

   // length, fill count, running sum, replay index
   always_comb begin
      count_in = count_ff;
      rcvd_in  = rcvd_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      if (accept && phase_ff == PH_LEN && len_ok) begin
         count_in = CW'(rx - FRAME_OVERHEAD);
         rcvd_in  = '0;
         sum_in   = '0;
      end
      if (wr_en) begin
         rcvd_in = rcvd_ff + CW'(1);
         sum_in  = sum_ff + rx;
      end
      if (rd_en) begin
         idx_in = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         rcvd_ff      <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rcvd_ff      <= rcvd_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload buffer; its read register is the result register
   scfr_store #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rcvd_ff[AW-1:0]),
      .wr_data (rx),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rsp_if.payload_byte)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.byte_index = INDEX_W'(idx_ff);
   assign rsp_if.last_byte  = last;

   // no input taken while a result beat is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_if.ready)
      else $error("input accepted during replay");

   // result beats only during replay
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (phase_ff == PH_REPLAY))
      else $error("result beat outside replay");

   // the final beat ends the run
   assert property (@(posedge clock) disable iff (reset)
      (beat && last) |=> !rsp_valid_ff)
      else $error("run continues after last beat");

   // indices advance by one within a run
   assert property (@(posedge clock) disable iff (reset)
      (beat && !last) |=>
         (rsp_valid_ff && rsp_if.byte_index == $past(rsp_if.byte_index) + INDEX_W'(1)))
      else $error("byte index skipped");

endmodule

>>> design/scfr_store.sv
// Payload buffer: one write port, one read port, registered read data.
// The read data register holds while rd_en is low.
module scfr_store
   import scfr_pkg::*;
#(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/tb_sum_checksum_frame_receiver.sv
module tb_sum_checksum_frame_receiver
   import scfr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 32;
   localparam int STORE_AW    = $clog2(MAX_PAYLOAD);
   localparam int ITEM_TARGET = 420;
   localparam int QUIET_TAIL  = 60;
   localparam int CYCLE_LIMIT = 200000;
   localparam int END_WAIT    = 2 * MAX_PAYLOAD + 8;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              drain;   // hold this byte until all payload has come out
   } rx_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  payload_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_byte;
   } payload_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scfr_req_if req_ch ();
   scfr_rsp_if rsp_ch ();

   sum_checksum_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   rx_item_type      rx_pending_q[$];
   payload_beat_type payload_due_q[$];

   // deframer shadow state
   phase_type         sh_phase;
   logic [BYTE_W-1:0] sh_count;
   logic [BYTE_W-1:0] sh_rcvd;
   logic [BYTE_W-1:0] sh_sum;
   logic [BYTE_W-1:0] sh_store [MAX_PAYLOAD];

   int  errors       = 0;
   int  cycles       = 0;
   int  bytes_in     = 0;
   int  beats_seen   = 0;
   int  frames_seen  = 0;
   int  drain_pauses = 0;
   logic req_fire    = 1'b0;
   int  req_gap      = 0;
   int  rsp_gap      = 0;
   logic quiet;

   assign quiet = (rx_pending_q.size() < QUIET_TAIL);

   // advance the shadow deframer by one received byte
   function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
      int cnt;
      payload_beat_type pb;
      case (sh_phase)
         PH_LEN: begin
            if (b <= FRAME_OVERHEAD || int'(b) > MAX_PAYLOAD + int'(FRAME_OVERHEAD)) begin
               sh_phase = PH_HUNT;
            end else begin
               sh_count = b - FRAME_OVERHEAD;
               sh_rcvd  = '0;
               sh_sum   = '0;
               sh_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (int'(sh_rcvd) < MAX_PAYLOAD) sh_store[sh_rcvd[STORE_AW-1:0]] = b;
            sh_sum  = sh_sum + b;
            sh_rcvd = sh_rcvd + 8'd1;
            if (sh_rcvd >= sh_count) sh_phase = PH_CHECK;
         end
         PH_CHECK: begin
            sh_phase = (b == sh_sum) ? PH_TRAILER : PH_HUNT;
         end
         PH_TRAILER: begin
            if (b == TRAILER_BYTE) begin
               cnt = (int'(sh_count) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(sh_count);
               for (int i = 0; i < cnt; i++) begin
                  pb.payload_byte = sh_store[i];
                  pb.byte_index   = INDEX_W'(i);
                  pb.last_byte    = (i + 1 == cnt);
                  payload_due_q.push_back(pb);
               end
            end
            sh_phase = PH_HUNT;
         end
         default: begin
            sh_phase = (b == HEADER_BYTE) ? PH_LEN : PH_HUNT;
         end
      endcase
   endfunction

   function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic drain = 1'b0);
      rx_item_type it;
      it.rx_byte = b;
      it.drain   = drain;
      rx_pending_q.push_back(it);
   endfunction

   // one frame with n random payload bytes; optional checksum or trailer fault
   function automatic void add_frame(input int n, input bit bad_sum, input bit bad_trailer,
                                     input logic drain = 1'b0);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      sum = '0;
      push_byte(HEADER_BYTE, drain);
      push_byte(BYTE_W'(n + 2));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0:       b = HEADER_BYTE;
            1:       b = TRAILER_BYTE;
            default: b = BYTE_W'($urandom_range(0, 255));
         endcase
         sum = sum + b;
         push_byte(b);
      end
      if (bad_sum) push_byte(sum ^ BYTE_W'($urandom_range(1, 255)));
      else         push_byte(sum);
      if (bad_trailer) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == TRAILER_BYTE) b = b ^ 8'h01;
         push_byte(b);
      end else begin
         push_byte(TRAILER_BYTE);
      end
   endfunction

   // stimulus, reset and end of run
   initial begin
      int frames;
      int n;
      int pick;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;

      sh_phase = PH_HUNT;
      sh_count = '0;
      sh_rcvd  = '0;
      sh_sum   = '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) sh_store[i] = '0;

      // noise while hunting
      push_byte(8'h00);
      push_byte(8'hFF);
      // bad lengths: zero, overhead only, one past the buffer
      push_byte(HEADER_BYTE); push_byte(8'd0);
      push_byte(HEADER_BYTE); push_byte(FRAME_OVERHEAD);
      push_byte(HEADER_BYTE); push_byte(BYTE_W'(MAX_PAYLOAD + 3));
      // shortest good frame
      push_byte(HEADER_BYTE); push_byte(8'd3); push_byte(8'hFF); push_byte(8'hFF);
      push_byte(TRAILER_BYTE);
      // checksum mismatch; the would-be trailer opens the next frame
      push_byte(HEADER_BYTE); push_byte(8'd4); push_byte(8'h01); push_byte(8'h02);
      push_byte(8'h00);
      push_byte(HEADER_BYTE); push_byte(8'd3); push_byte(8'hAA); push_byte(8'hAA);
      push_byte(TRAILER_BYTE);
      // wrong trailer; the sender first waits for the payload above to drain
      push_byte(HEADER_BYTE, 1'b1); push_byte(8'd3); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'hBA);

      // random part: mostly good frames, some faults and noise
      frames = 0;
      while (rx_pending_q.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         n = ($urandom_range(0, 19) == 0) ? MAX_PAYLOAD :
             ($urandom_range(0, 5) == 0)  ? $urandom_range(9, MAX_PAYLOAD - 1) :
                                            $urandom_range(1, 8);
         if (pick < 68) begin
            add_frame(n, 1'b0, 1'b0, (frames == 6 || frames == 25));
         end else if (pick < 78) begin
            add_frame(n, 1'b1, 1'b0);
         end else if (pick < 84) begin
            add_frame(n, 1'b0, 1'b1);
         end else if (pick < 90) begin
            push_byte(HEADER_BYTE);
            push_byte(($urandom_range(0, 1) == 1) ? BYTE_W'($urandom_range(0, 2)) :
                                                    BYTE_W'($urandom_range(MAX_PAYLOAD + 3, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
         end
         frames++;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all bytes taken, then all payload out, then a short settle
      while (rx_pending_q.size() != 0 || req_ch.valid) @(posedge clock);
      while (payload_due_q.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);

      $display("Run covered %0d received bytes, %0d validated frames, %0d payload beats.",
               bytes_in, frames_seen, beats_seen);
      $display("Sender held off %0d times for a full drain; %0d mismatches.",
               drain_pauses, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // byte driver
   always @(negedge clock) begin
      logic              nv;
      logic [BYTE_W-1:0] nb;
      rx_item_type       head;
      nv = 1'b0;
      nb = req_ch.rx_byte;
      if (reset) begin
         nv = 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         nv = 1'b1;
      end else if (req_gap > 0) begin
         req_gap--;
      end else if (rx_pending_q.size() == 0) begin
         nv = 1'b0;
      end else if (rx_pending_q[0].drain && payload_due_q.size() != 0) begin
         nv = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(0, 11);
      end else begin
         if (rx_pending_q[0].drain) drain_pauses++;
         nv   = 1'b1;
         head = rx_pending_q.pop_front();
         nb   = head.rx_byte;
      end
      req_ch.valid   <= nv;
      req_ch.rx_byte <= nb;
   end

   // payload sink backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 11);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // accept bytes into the shadow model and check payload beats
   always @(posedge clock) begin
      payload_beat_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            bytes_in++;
            track_rx_byte(req_ch.rx_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
            if (rsp_ch.last_byte === 1'b1) frames_seen++;
            if (payload_due_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected payload beat byte=%h index=%0d last=%b", $time,
                        rsp_ch.payload_byte, rsp_ch.byte_index, rsp_ch.last_byte);
            end else begin
               want = payload_due_q.pop_front();
               if (rsp_ch.payload_byte !== want.payload_byte) begin
                  errors++;
                  $display("%0t: payload_byte expected %h actual %h", $time,
                           want.payload_byte, rsp_ch.payload_byte);
               end
               if (rsp_ch.byte_index !== want.byte_index) begin
                  errors++;
                  $display("%0t: byte_index expected %0d actual %0d", $time,
                           want.byte_index, rsp_ch.byte_index);
               end
               if (rsp_ch.last_byte !== want.last_byte) begin
                  errors++;
                  $display("%0t: last_byte expected %b actual %b", $time,
                           want.last_byte, rsp_ch.last_byte);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d bytes unsent, %0d payload beats outstanding", $time,
                  rx_pending_q.size(), payload_due_q.size());
         $display("Verification failed");
         $finish;
      end
   end

endmodule
